// ===== hdl/rcfe_pkg.sv =====
// Package for the RC channel frame encoder.
// Item types, frame constants, channel mapping constants and the CRC-8 update.
// No dependencies.
package rcfe_pkg;

    localparam int CHAN_W     = 11;
    localparam int LIVE_SLOTS = 8;
    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int LIVE_W     = $clog2(LIVE_SLOTS);
    localparam int DATA_BYTES = 22;
    localparam int FRAME_BYTES = 26;
    localparam int DCNT_W     = $clog2(DATA_BYTES);
    localparam int FCNT_W     = $clog2(FRAME_BYTES);
    localparam int ACC_W      = 18;
    localparam int HELD_W     = 4;

    localparam logic [CHAN_W-1:0] IN_MIN  = 11'd1000;
    localparam logic [CHAN_W-1:0] IN_MAX  = 11'd2000;
    localparam logic [CHAN_W-1:0] OUT_MIN = 11'd192;
    localparam logic [CHAN_W-1:0] DEFAULT_RESET = 11'd992;

    // (d * 1600) / 1000 == (8 * d) / 5; divide by 5 as multiply by 13108 >> 16,
    // exact for 8 * d up to 8000.
    localparam int RECIP5       = 13108;
    localparam int RECIP_SHIFT  = 16;
    localparam int PROD_W       = 28;

    localparam logic [7:0] FRAME_ADDR = 8'hEE;
    localparam logic [7:0] FRAME_LEN  = 8'd24;
    localparam logic [7:0] FRAME_TYPE = 8'h16;
    localparam logic [7:0] CRC_POLY   = 8'hD5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [CHAN_W-1:0] aileron;
        logic [CHAN_W-1:0] elevator;
        logic [CHAN_W-1:0] throttle;
        logic [CHAN_W-1:0] rudder;
        logic [CHAN_W-1:0] switch_a;
        logic [CHAN_W-1:0] switch_b;
        logic [CHAN_W-1:0] switch_c;
        logic [CHAN_W-1:0] switch_d;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic {
        F_IDLE,
        F_RUN
    } front_state_t;

    typedef enum logic [2:0] {
        B_ADDR,
        B_LEN,
        B_TYPE,
        B_DATA,
        B_CRC
    } back_state_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    localparam logic [7:0] CRC_AFTER_TYPE = crc8_update(8'h00, FRAME_TYPE);

endpackage

// ===== hdl/rcfe_fifo.sv =====
// Small FIFO of 11-bit channel values between front and back end.
// Depends on rcfe_pkg.
module rcfe_fifo
    import rcfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [CHAN_W-1:0] push_value,
    input  logic              pop,
    output logic [CHAN_W-1:0] pop_value,
    output fifo_stat_t        stat
);

    logic [CHAN_W-1:0]  mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_value  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_value;
    end

endmodule

// ===== hdl/rcfe_front.sv =====
// Front end: takes a channel set, maps the eight live channels one per cycle
// while the FIFO has room and queues all sixteen slot values. Depends on rcfe_pkg.
module rcfe_front
    import rcfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    input  logic [CHAN_W-1:0] dflt_value,
    input  fifo_stat_t        fifo_stat,
    output logic              push,
    output logic [CHAN_W-1:0] push_value
);

    front_state_t      state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CHAN_W-1:0] raw_reg [LIVE_SLOTS];

    logic [CHAN_W-1:0] raw_sel;
    logic [CHAN_W-1:0] clamped;
    logic [9:0]        diff;
    logic [PROD_W-1:0] prod;
    logic [CHAN_W-1:0] mapped;
    logic              accept;

    assign accept = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                    state_next = F_RUN;
            end
            F_RUN:
            begin
                if (!fifo_stat.full && slot_reg == SLOT_W'(SLOTS - 1))
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall = 1'b1;
        push     = 1'b0;
        case (state_reg)
            F_IDLE: in_stall = 1'b0;
            F_RUN:  push     = !fifo_stat.full;
            default:
            begin
                in_stall = 1'b1;
                push     = 1'b0;
            end
        endcase
    end

    // clamp, then (x - 1000) * 8 / 5 + 192
    always_comb
    begin
        raw_sel = raw_reg[slot_reg[LIVE_W-1:0]];
        if (raw_sel < IN_MIN)
            clamped = IN_MIN;
        else if (raw_sel > IN_MAX)
            clamped = IN_MAX;
        else
            clamped = raw_sel;
        diff   = 10'(clamped - IN_MIN);
        prod   = PROD_W'({diff, 3'b000}) * PROD_W'(RECIP5);
        mapped = prod[RECIP_SHIFT +: CHAN_W] + OUT_MIN;
        push_value = slot_reg[SLOT_W-1] ? dflt_value : mapped;
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (accept)
            slot_next = '0;
        else if (push)
            slot_next = slot_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg[0] <= in_data.aileron;
            raw_reg[1] <= in_data.elevator;
            raw_reg[2] <= in_data.throttle;
            raw_reg[3] <= in_data.rudder;
            raw_reg[4] <= in_data.switch_a;
            raw_reg[5] <= in_data.switch_b;
            raw_reg[6] <= in_data.switch_c;
            raw_reg[7] <= in_data.switch_d;
        end
    end

endmodule

// ===== hdl/rcfe_back.sv =====
// Back end: header bytes, LSB-first packing of queued 11-bit values, CRC-8,
// and the output register. Depends on rcfe_pkg.
module rcfe_back
    import rcfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fifo_stat_t        fifo_stat,
    input  logic [CHAN_W-1:0] pop_value,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data
);

    back_state_t       state_reg, state_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [DCNT_W-1:0] count_reg, count_next;
    logic [7:0]        crc_reg, crc_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg;

    logic              load_ok;
    logic              need_pop;
    logic              emit;
    out_item_t         emit_item;
    logic [ACC_W-1:0]  combined;

    assign load_ok   = !out_valid_reg || !out_stall;
    assign need_pop  = (held_reg < HELD_W'(8));
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_ADDR:
            begin
                if (load_ok && !fifo_stat.empty)
                    state_next = B_LEN;
            end
            B_LEN:
            begin
                if (load_ok)
                    state_next = B_TYPE;
            end
            B_TYPE:
            begin
                if (load_ok)
                    state_next = B_DATA;
            end
            B_DATA:
            begin
                if (emit && count_reg == DCNT_W'(DATA_BYTES - 1))
                    state_next = B_CRC;
            end
            B_CRC:
            begin
                if (load_ok)
                    state_next = B_ADDR;
            end
            default: state_next = B_ADDR;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        emit       = 1'b0;
        pop        = 1'b0;
        emit_item  = '0;
        acc_next   = acc_reg;
        held_next  = held_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        combined   = acc_reg | (ACC_W'(pop_value) << held_reg);
        case (state_reg)
            B_ADDR:
            begin
                // a frame starts once its first value is queued
                emit                 = load_ok && !fifo_stat.empty;
                emit_item.frame_byte = FRAME_ADDR;
            end
            B_LEN:
            begin
                emit                 = load_ok;
                emit_item.frame_byte = FRAME_LEN;
            end
            B_TYPE:
            begin
                emit                 = load_ok;
                emit_item.frame_byte = FRAME_TYPE;
                if (load_ok)
                begin
                    acc_next   = '0;
                    held_next  = '0;
                    count_next = '0;
                    crc_next   = CRC_AFTER_TYPE;
                end
            end
            B_DATA:
            begin
                // below 8 bits held, merge the next value and still emit a byte
                emit = load_ok && (!need_pop || !fifo_stat.empty);
                pop  = emit && need_pop;
                if (need_pop)
                begin
                    emit_item.frame_byte = combined[7:0];
                    if (emit)
                    begin
                        acc_next  = combined >> 8;
                        held_next = held_reg + HELD_W'(CHAN_W - 8);
                    end
                end
                else
                begin
                    emit_item.frame_byte = acc_reg[7:0];
                    if (emit)
                    begin
                        acc_next  = acc_reg >> 8;
                        held_next = held_reg - HELD_W'(8);
                    end
                end
                if (emit)
                begin
                    count_next = count_reg + 1'b1;
                    crc_next   = crc8_update(crc_reg, emit_item.frame_byte);
                end
            end
            B_CRC:
            begin
                emit                 = load_ok;
                emit_item.frame_byte = crc_reg;
                emit_item.last_byte  = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
                pop  = 1'b0;
            end
        endcase
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_ADDR;
            acc_reg       <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_item_reg <= emit_item;
    end

endmodule

// ===== hdl/rc_channel_frame_encoder.sv =====
// RC channel frame encoder, top level.
// Ties the default-value register, front end, value FIFO and back end together.
// Depends on rcfe_pkg, rcfe_front, rcfe_fifo, rcfe_back.

// Each accepted item (eight channel pulse widths) yields one 26-byte RC-channels
// frame: 0xEE, 24, 0x16, sixteen 11-bit values packed LSB-first in 22 bytes,
// and a CRC-8 (poly 0xD5, init 0, over type and payload), with last_byte set
// on the CRC byte. Channels are clamped to 1000..2000 and scaled to 192..1792;
// slots 8 to 15 carry default_channel_value (reset 992), written through the
// cfg channel, which is always ready. The output side sends one byte per cycle
// while the receiver does not stall. The front end maps one channel per cycle,
// but the four-entry value FIFO paces it to the byte serializer; the next item
// is taken once all sixteen values of the last are queued, while the back end
// may still be sending the previous frame.
module rc_channel_frame_encoder
    import rcfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CHAN_W-1:0] cfg_data
);

    logic [CHAN_W-1:0] dflt_reg;
    logic              push;
    logic [CHAN_W-1:0] push_value;
    logic              pop;
    logic [CHAN_W-1:0] pop_value;
    fifo_stat_t        fifo_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dflt_reg <= DEFAULT_RESET;
        else if (cfg_valid && cfg_ready)
            dflt_reg <= cfg_data;
    end

    rcfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .dflt_value (dflt_reg),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_value (push_value)
    );

    rcfe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_value (push_value),
        .pop        (pop),
        .pop_value  (pop_value),
        .stat       (fifo_stat)
    );

    rcfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_stat  (fifo_stat),
        .pop_value  (pop_value),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ===== hdl/rcfe_checker.sv =====
// Port-level checks for the RC channel frame encoder, bound to the top level.
// Depends on rcfe_pkg and rc_channel_frame_encoder.
module rcfe_checker
    import rcfe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input out_item_t         out_data
);

    logic [FCNT_W-1:0] pos_reg, pos_next;
    logic              out_take;

    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        pos_next = pos_reg;
        if (out_take)
            pos_next = (pos_reg == FCNT_W'(FRAME_BYTES - 1)) ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output item changed");

    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a frame is being built");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (out_data.last_byte == (pos_reg == FCNT_W'(FRAME_BYTES - 1))))
        else $error("last_byte not on the 26th item of a frame");

    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && pos_reg == '0 |-> out_data.frame_byte == FRAME_ADDR)
        else $error("frame does not start with the address byte");

    a_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && pos_reg == FCNT_W'(2) |-> out_data.frame_byte == FRAME_TYPE)
        else $error("third frame byte is not the type byte");

endmodule

bind rc_channel_frame_encoder rcfe_checker u_rcfe_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for rc_channel_frame_encoder: drives channel sets, predicts
// each 26-byte RC-channels frame and compares every byte as it leaves the block.
// Depends on rcfe_pkg and the rc_channel_frame_encoder RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rcfe_pkg::*;

    class frame_tracker;
        out_item_t   due_bytes[$];
        int unsigned mismatches;

        function logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] raw);
            int unsigned x;
            x = raw;
            if (x < 1000) x = 1000;
            if (x > 2000) x = 2000;
            return CHAN_W'(((x - 1000) * 1600) / 1000 + 192);
        endfunction

        // MSB-first CRC-8, one input bit per shift
        function logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb  = crc[7] ^ b[i];
                crc = {crc[6:0], 1'b0};
                if (fb)
                    crc = crc ^ CRC_POLY;
            end
            return crc;
        endfunction

        function void add_byte(input logic [7:0] b, input logic last);
            out_item_t ob;
            ob.frame_byte = b;
            ob.last_byte  = last;
            due_bytes.push_back(ob);
        endfunction

        function void log_channels(input in_item_t it, input logic [CHAN_W-1:0] dflt);
            logic [CHAN_W-1:0]        raw [LIVE_SLOTS];
            logic [SLOTS*CHAN_W-1:0]  slot_bits;
            logic [7:0]               crc;
            logic [7:0]               b;
            raw[0] = it.aileron;
            raw[1] = it.elevator;
            raw[2] = it.throttle;
            raw[3] = it.rudder;
            raw[4] = it.switch_a;
            raw[5] = it.switch_b;
            raw[6] = it.switch_c;
            raw[7] = it.switch_d;
            slot_bits = '0;
            for (int s = 0; s < SLOTS; s++)
                slot_bits[s*CHAN_W +: CHAN_W] = (s < LIVE_SLOTS) ? scale_channel(raw[s]) : dflt;
            add_byte(FRAME_ADDR, 1'b0);
            add_byte(FRAME_LEN, 1'b0);
            add_byte(FRAME_TYPE, 1'b0);
            crc = crc_byte(8'h00, FRAME_TYPE);
            for (int k = 0; k < DATA_BYTES; k++)
            begin
                b   = slot_bits[k*8 +: 8];
                crc = crc_byte(crc, b);
                add_byte(b, 1'b0);
            end
            add_byte(crc, 1'b1);
        endfunction

        function void match_byte(input out_item_t got);
            out_item_t want;
            if (due_bytes.size() == 0)
            begin
                $error("frame_byte: expected none, actual %02h", got.frame_byte);
                mismatches++;
                return;
            end
            want = due_bytes.pop_front();
            if (got.frame_byte !== want.frame_byte)
            begin
                $error("frame_byte: expected %02h, actual %02h", want.frame_byte, got.frame_byte);
                mismatches++;
            end
            if (got.last_byte !== want.last_byte)
            begin
                $error("last_byte: expected %0b, actual %0b", want.last_byte, got.last_byte);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_item_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CHAN_W-1:0] cfg_data  = '0;

    frame_tracker      book = new();
    logic [CHAN_W-1:0] slot_default = DEFAULT_RESET;
    int                send_pct = 0;
    int                recv_pct = 0;

    rc_channel_frame_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[rc_channel_frame_encoder] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_pct);
    end

    // all handshakes observed on the edge, before the block's own updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                book.log_channels(in_data, slot_default);
            if (out_valid && !out_stall)
                book.match_byte(out_data);
            if (cfg_valid && cfg_ready)
                slot_default = cfg_data;
        end
    end

    function automatic logic [CHAN_W-1:0] pick_pulse();
        logic [CHAN_W-1:0] v;
        case ($urandom_range(9))
            7:       v = CHAN_W'($urandom_range(2047));
            8, 9:
            begin
                case ($urandom_range(5))
                    0:       v = 11'd1000;
                    1:       v = 11'd2000;
                    2:       v = 11'd999;
                    3:       v = 11'd2001;
                    4:       v = 11'd0;
                    default: v = 11'd2047;
                endcase
            end
            default: v = CHAN_W'($urandom_range(2000, 1000));
        endcase
        return v;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.aileron  = pick_pulse();
        it.elevator = pick_pulse();
        it.throttle = pick_pulse();
        it.rudder   = pick_pulse();
        it.switch_a = pick_pulse();
        it.switch_b = pick_pulse();
        it.switch_c = pick_pulse();
        it.switch_d = pick_pulse();
        return it;
    endfunction

    function automatic in_item_t all_channels(input logic [CHAN_W-1:0] v);
        return in_item_t'{v, v, v, v, v, v, v, v};
    endfunction

    // called on a clock edge; returns on the edge where the item is taken
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_default(input logic [CHAN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (book.due_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int sp, input int rp, input int n);
        wait_idle();
        send_pct = sp;
        recv_pct = rp;
        write_default(CHAN_W'($urandom_range(2047)));
        repeat (n) send_item(random_item());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_pct = 32;
        recv_pct = 86;

        // reset default in the spare slots; limits, saturation both ways
        send_item(all_channels(11'd1000));
        send_item(all_channels(11'd2000));
        send_item(all_channels(11'd0));
        send_item(all_channels(11'd2047));
        send_item(all_channels(11'd999));
        send_item(all_channels(11'd2001));
        send_item(all_channels(11'd1500));
        send_item(in_item_t'{11'd1000, 11'd2000, 11'd1000, 11'd2000,
                             11'd1000, 11'd2000, 11'd1000, 11'd2000});
        send_item(in_item_t'{11'd0, 11'd2047, 11'd999, 11'd2001,
                             11'd1001, 11'd1999, 11'd1234, 11'd1765});
        send_item(all_channels(11'h555));
        send_item(all_channels(11'h2AA));

        wait_idle();
        write_default(11'd2047);
        send_item(all_channels(11'd1000));
        send_item(all_channels(11'd2000));
        send_item(random_item());

        wait_idle();
        write_default(11'd0);
        send_item(all_channels(11'd2000));
        send_item(all_channels(11'd1000));
        send_item(random_item());

        run_phase(32, 86, 150);
        run_phase(86, 32, 150);
        run_phase(0, 0, 160);

        wait_idle();
        repeat (40) @(posedge clk);
        if (book.mismatches == 0 && book.due_bytes.size() == 0)
            $display("[rc_channel_frame_encoder] OK");
        else
            $display("[rc_channel_frame_encoder] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rcfe_pkg.sv
hdl/rcfe_fifo.sv
hdl/rcfe_front.sv
hdl/rcfe_back.sv
hdl/rc_channel_frame_encoder.sv
hdl/rcfe_checker.sv
bench/testbench.sv
